// ===== rtl/ooe_pkg.sv =====
// Shared types, constants and helper functions of the omni odometry velocity estimator.
// Depends on nothing; the top level, rotation unit, output lanes and testbench import it.
package ooe_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    // Divider geometry: numerators reach 116 bits, the turn-rate divisor 74 bits.
    localparam int NUM_W = 128;
    localparam int DEN_W = 80;

    // Fixed-point constants of the kinematics.
    localparam logic [63:0] SQRT3_Q30 = 64'd1859775393;
    localparam logic [63:0] TWOPI_Q28 = 64'd1686629713;
    localparam logic [63:0] K_XY      = 64'd3000;
    localparam logic [63:0] K_TURN    = 64'd3;
    localparam logic [63:0] K_MILLI   = 64'd1000;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam int CORDIC_STEPS = 30;

    // Configuration register indexes.
    localparam logic [7:0] REG_MIN_TICKS  = 8'd0;
    localparam logic [7:0] REG_TICKS_REV  = 8'd1;
    localparam logic [7:0] REG_WHEEL_RAD  = 8'd2;
    localparam logic [7:0] REG_BODY_RAD   = 8'd3;

    typedef struct packed {
        logic signed [31:0] count_a;
        logic signed [31:0] count_b;
        logic signed [31:0] count_c;
        logic        [31:0] time_ms;
        logic signed [15:0] heading;
    } item_t;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] turn_rate;
        logic               zero_interval;
    } result_t;

    // Sine and cosine handed from the rotation unit to the sequencer.
    typedef struct packed {
        logic               valid;
        logic signed [33:0] cos_v;
        logic signed [33:0] sin_v;
    } cs_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SINCOS,
        ST_MUL_ISSUE,
        ST_MUL_WAIT,
        ST_DIV_ISSUE,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Multiply steps of the sequencer, in execution order.
    typedef enum logic [3:0] {
        SP_Q,
        SP_CQ,
        SP_SP,
        SP_SQ,
        SP_CP,
        SP_G,
        SP_G1K,
        SP_NX,
        SP_NY,
        SP_NT,
        SP_K3K,
        SP_DXY,
        SP_K3,
        SP_D3,
        SP_DT
    } step_t;

    // Arctangent table, 2^32 units per turn.
    function automatic logic [29:0] arc_angle(input logic [4:0] i);
        logic [29:0] a;
        begin
            case (i)
                5'd0:  a = 30'd536870912;
                5'd1:  a = 30'd316933406;
                5'd2:  a = 30'd167458907;
                5'd3:  a = 30'd85004756;
                5'd4:  a = 30'd42667331;
                5'd5:  a = 30'd21354465;
                5'd6:  a = 30'd10679838;
                5'd7:  a = 30'd5340245;
                5'd8:  a = 30'd2670163;
                5'd9:  a = 30'd1335087;
                5'd10: a = 30'd667544;
                5'd11: a = 30'd333772;
                5'd12: a = 30'd166886;
                5'd13: a = 30'd83443;
                5'd14: a = 30'd41722;
                5'd15: a = 30'd20861;
                5'd16: a = 30'd10430;
                5'd17: a = 30'd5215;
                5'd18: a = 30'd2608;
                5'd19: a = 30'd1304;
                5'd20: a = 30'd652;
                5'd21: a = 30'd326;
                5'd22: a = 30'd163;
                5'd23: a = 30'd81;
                5'd24: a = 30'd41;
                5'd25: a = 30'd20;
                5'd26: a = 30'd10;
                5'd27: a = 30'd5;
                5'd28: a = 30'd3;
                5'd29: a = 30'd1;
                default: a = 30'd0;
            endcase
            return a;
        end
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        begin
            return v[63] ? 64'(-v) : 64'(v);
        end
    endfunction

endpackage

// ===== rtl/omni_odometry_velocity_estimator.sv =====
// Operation: an item that moves no wheel is absorbed in its accepting cycle; a zero interval
// passes through the emit state into the output register; any other moving item passes
// through the 30-step rotation unit, 15 multiply steps on one 32 x 32 multiplier, and the
// 128-step dividers of the three output lanes, which run side by side; a full output
// register holds the emit state until the receiver takes the last word.
// Throughput: one item at a time; a new item is taken only after the last word is emitted.
// Reset clears saved counts and time, loads the register defaults and empties the output.
module omni_odometry_velocity_estimator #(
    parameter int COUNT_WIDTH = ooe_pkg::COUNT_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  ooe_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output ooe_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import ooe_pkg::*;

    // Configuration registers.
    logic [15:0] min_ticks_reg, ticks_rev_reg;
    logic [19:0] wheel_rad_reg;
    logic [23:0] body_rad_reg;
    logic [15:0] tpr_eff;
    logic [23:0] brad_eff;

    // Odometry state kept from the last update.
    logic [COUNT_WIDTH-1:0] saved_cnt_reg [3];
    logic [31:0]            saved_time_reg;

    // Wheel lanes.
    logic signed [31:0]            lane_count [3];
    logic [COUNT_WIDTH-1:0]        lane_cur   [3];
    logic signed [COUNT_WIDTH-1:0] lane_diff  [3];
    logic [2:0]                    lane_moved;
    logic                          any_moved;
    logic [31:0]                   dt_now;

    // Working registers of the kinematics.
    state_t state_reg, state_next;
    step_t  step_reg;
    logic signed [63:0] d_reg [3];
    logic signed [63:0] u_reg, p_reg, sum_reg, q_reg, t1_reg, lx_reg, ly_reg;
    logic signed [63:0] pq, cos64, sin64;
    logic [63:0]        g_reg, g1k_reg, k_reg, dxy_reg;
    logic [DEN_W-1:0]   dtb_reg;
    logic [NUM_W-1:0]   nx_reg, ny_reg, nt_reg;
    logic [31:0]        dt_reg;
    logic               zero_reg;
    result_t            result_reg;
    logic               result_valid_reg;

    // Shared units and their handshakes.
    logic         accept, start_calc, cordic_start, mul_start, div_start;
    cs_t          cs;
    logic [63:0]  mul_a, mul_b;
    logic         mul_neg, mul_done;
    logic [127:0] mul_prod, p30, p14;
    logic [62:0]  m30, m14;
    logic signed [63:0] ms30, ms14;
    logic [2:0]         div_done;
    logic signed [31:0] div_val [3];

    assign cfg_ready = 1'b1;
    assign tpr_eff   = (ticks_rev_reg == 16'd0) ? 16'd1 : ticks_rev_reg;
    assign brad_eff  = (body_rad_reg == 24'd0) ? 24'd1 : body_rad_reg;

    // Register writes; an index past the last register is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_ticks_reg <= 16'd10;
            ticks_rev_reg <= 16'd150;
            wheel_rad_reg <= 20'd19000;
            body_rad_reg  <= 24'd67500;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MIN_TICKS: min_ticks_reg <= cfg_data[15:0];
                REG_TICKS_REV: ticks_rev_reg <= cfg_data[15:0];
                REG_WHEEL_RAD: wheel_rad_reg <= cfg_data[19:0];
                REG_BODY_RAD:  body_rad_reg  <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // The three wheel lanes work on the counts of one word at once; their motion flags
    // merge into one decision.
    assign lane_count[0] = item.count_a;
    assign lane_count[1] = item.count_b;
    assign lane_count[2] = item.count_c;

    for (genvar w = 0; w < 3; w++)
    begin : g_wheel
        ooe_wheel_lane #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_lane (
            .count     (lane_count[w]),
            .saved     (saved_cnt_reg[w]),
            .min_ticks (min_ticks_reg),
            .cur       (lane_cur[w]),
            .diff      (lane_diff[w]),
            .moved     (lane_moved[w])
        );
    end

    assign any_moved  = |lane_moved;
    assign dt_now     = item.time_ms - saved_time_reg;
    assign accept     = item_valid && item_ready;
    assign start_calc = accept && any_moved && (dt_now != 32'd0);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && any_moved)
                begin
                    state_next = (dt_now == 32'd0) ? ST_EMIT : ST_PREP;
                end
            end
            ST_PREP:      state_next = ST_SINCOS;
            ST_SINCOS:    state_next = cs.valid ? ST_MUL_ISSUE : ST_SINCOS;
            ST_MUL_ISSUE: state_next = ST_MUL_WAIT;
            ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = (step_reg == SP_DT) ? ST_DIV_ISSUE : ST_MUL_ISSUE;
                end
            end
            ST_DIV_ISSUE: state_next = ST_DIV;
            ST_DIV:       state_next = div_done[0] ? ST_EMIT : ST_DIV;
            ST_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        item_ready   = state_reg == ST_IDLE;
        cordic_start = (state_reg == ST_IDLE) && start_calc;
        mul_start    = state_reg == ST_MUL_ISSUE;
        div_start    = state_reg == ST_DIV_ISSUE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= SP_Q;
            saved_cnt_reg[0] <= '0;
            saved_cnt_reg[1] <= '0;
            saved_cnt_reg[2] <= '0;
            saved_time_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && any_moved)
            begin
                saved_cnt_reg[0] <= lane_cur[0];
                saved_cnt_reg[1] <= lane_cur[1];
                saved_cnt_reg[2] <= lane_cur[2];
                saved_time_reg   <= item.time_ms;
            end
            if (state_reg == ST_PREP)
            begin
                step_reg <= SP_Q;
            end
            else if (state_reg == ST_MUL_WAIT && mul_done && step_reg != SP_DT)
            begin
                step_reg <= step_t'(step_reg + 4'd1);
            end
            if (state_reg == ST_EMIT && (!result_valid_reg || result_ready))
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Rotation unit for cosine and sine of the heading.
    ooe_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .heading (item.heading),
        .cs      (cs)
    );

    assign cos64 = 64'(cs.cos_v);
    assign sin64 = 64'(cs.sin_v);
    assign pq    = p_reg <<< 16;

    // Operand selection for the shared multiplier; signed products go in as magnitudes
    // and take their sign back afterwards.
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        unique case (step_reg)
            SP_Q:
            begin
                mul_a   = mag64(u_reg);
                mul_b   = SQRT3_Q30;
                mul_neg = u_reg[63];
            end
            SP_CQ:
            begin
                mul_a   = mag64(cos64);
                mul_b   = mag64(q_reg);
                mul_neg = cos64[63] ^ q_reg[63];
            end
            SP_SP:
            begin
                mul_a   = mag64(sin64);
                mul_b   = mag64(pq);
                mul_neg = sin64[63] ^ pq[63];
            end
            SP_SQ:
            begin
                mul_a   = mag64(sin64);
                mul_b   = mag64(q_reg);
                mul_neg = sin64[63] ^ q_reg[63];
            end
            SP_CP:
            begin
                mul_a   = mag64(cos64);
                mul_b   = mag64(pq);
                mul_neg = cos64[63] ^ pq[63];
            end
            SP_G:
            begin
                mul_a = 64'(wheel_rad_reg);
                mul_b = TWOPI_Q28;
            end
            SP_G1K:
            begin
                mul_a = g_reg;
                mul_b = K_MILLI;
            end
            SP_NX:
            begin
                mul_a = mag64(lx_reg);
                mul_b = g_reg;
            end
            SP_NY:
            begin
                mul_a = mag64(ly_reg);
                mul_b = g_reg;
            end
            SP_NT:
            begin
                mul_a = mag64(sum_reg);
                mul_b = g1k_reg;
            end
            SP_K3K:
            begin
                mul_a = 64'(tpr_eff);
                mul_b = K_XY;
            end
            SP_DXY:
            begin
                mul_a = k_reg;
                mul_b = 64'(dt_reg);
            end
            SP_K3:
            begin
                mul_a = 64'(tpr_eff);
                mul_b = K_TURN;
            end
            SP_D3:
            begin
                mul_a = k_reg;
                mul_b = 64'(dt_reg);
            end
            SP_DT:
            begin
                mul_a = k_reg;
                mul_b = 64'(brad_eff);
            end
            default: ;
        endcase
    end

    ooe_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_prod),
        .done  (mul_done)
    );

    // Scaled products clamp to the largest positive 64-bit value before the sign returns.
    assign p30  = mul_prod >> 30;
    assign p14  = mul_prod >> 14;
    assign m30  = (|p30[127:63]) ? '1 : p30[62:0];
    assign m14  = (|p14[127:63]) ? '1 : p14[62:0];
    assign ms30 = mul_neg ? -signed'({1'b0, m30}) : signed'({1'b0, m30});
    assign ms14 = mul_neg ? -signed'({1'b0, m14}) : signed'({1'b0, m14});

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d_reg[0]    <= 64'(lane_diff[0]);
            d_reg[1]    <= 64'(lane_diff[1]);
            d_reg[2]    <= 64'(lane_diff[2]);
            dt_reg      <= dt_now;
            zero_reg    <= dt_now == 32'd0;
        end
        if (state_reg == ST_PREP)
        begin
            u_reg   <= d_reg[2] - d_reg[1];
            p_reg   <= (d_reg[0] <<< 1) - d_reg[1] - d_reg[2];
            sum_reg <= d_reg[0] + d_reg[1] + d_reg[2];
        end
        if (state_reg == ST_MUL_WAIT && mul_done)
        begin
            case (step_reg)
                SP_Q:    q_reg   <= ms14;
                SP_CQ:   t1_reg  <= ms30;
                SP_SP:   lx_reg  <= t1_reg - ms30;
                SP_SQ:   t1_reg  <= ms30;
                SP_CP:   ly_reg  <= t1_reg + ms30;
                SP_G:    g_reg   <= mul_prod[63:0];
                SP_G1K:  g1k_reg <= mul_prod[63:0];
                SP_NX:   nx_reg  <= mul_prod >> 28;
                SP_NY:   ny_reg  <= mul_prod >> 28;
                SP_NT:   nt_reg  <= mul_prod >> 12;
                SP_K3K:  k_reg   <= mul_prod[63:0];
                SP_DXY:  dxy_reg <= mul_prod[63:0];
                SP_K3:   k_reg   <= mul_prod[63:0];
                SP_D3:   k_reg   <= mul_prod[63:0];
                SP_DT:   dtb_reg <= mul_prod[DEN_W-1:0];
                default: ;
            endcase
        end
        if (state_reg == ST_EMIT && (!result_valid_reg || result_ready))
        begin
            result_reg.vel_x         <= zero_reg ? 32'sd0 : div_val[0];
            result_reg.vel_y         <= zero_reg ? 32'sd0 : div_val[1];
            result_reg.turn_rate     <= zero_reg ? 32'sd0 : div_val[2];
            result_reg.zero_interval <= zero_reg;
        end
    end

    // Output lanes: x and y velocity share one divisor, the turn rate folds the body
    // radius into its own.
    ooe_div_lane u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (nx_reg),
        .den   (DEN_W'(dxy_reg)),
        .neg   (lx_reg[63]),
        .done  (div_done[0]),
        .value (div_val[0])
    );

    ooe_div_lane u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (ny_reg),
        .den   (DEN_W'(dxy_reg)),
        .neg   (ly_reg[63]),
        .done  (div_done[1]),
        .value (div_val[1])
    );

    ooe_div_lane u_div_t (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (nt_reg),
        .den   (dtb_reg),
        .neg   (sum_reg[63]),
        .done  (div_done[2]),
        .value (div_val[2])
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The three output lanes run in lock step.
    a_lanes_together: assert property (@(posedge clk) disable iff (!rst_n)
        div_done[0] |-> (div_done[1] && div_done[2]))
        else $error("output lanes finished apart");

    // A multiply finishes only while the sequencer waits for it.
    a_mul_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL_WAIT))
        else $error("multiplier finished outside a wait");

    // Saved time moves only with an accepted word.
    a_time_update: assert property (@(posedge clk) disable iff (!rst_n)
        (saved_time_reg != $past(saved_time_reg)) |-> $past(accept))
        else $error("saved time changed without a word");

    // A zero interval reports zero velocities.
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.zero_interval) |->
            (result.vel_x == 32'sd0 && result.vel_y == 32'sd0 && result.turn_rate == 32'sd0))
        else $error("zero interval with nonzero velocity");

endmodule

// ===== rtl/ooe_wheel_lane.sv =====
// One wheel lane: current count, wrapped tick change and the motion test.
// Depends on ooe_pkg for nothing but the house conventions; purely combinational.
module ooe_wheel_lane #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic signed [31:0]          count,
    input  logic [COUNT_WIDTH-1:0]      saved,
    input  logic [15:0]                 min_ticks,
    output logic [COUNT_WIDTH-1:0]      cur,
    output logic signed [COUNT_WIDTH-1:0] diff,
    output logic                        moved
);
    logic signed [63:0]     count_ext;
    logic [COUNT_WIDTH-1:0] diff_mag;

    // The count is sign-extended and then kept modulo 2^COUNT_WIDTH.
    assign count_ext = 64'(count);
    assign cur       = count_ext[COUNT_WIDTH-1:0];
    assign diff      = cur - saved;
    assign diff_mag  = diff[COUNT_WIDTH-1] ? COUNT_WIDTH'(-diff) : COUNT_WIDTH'(diff);
    assign moved     = diff_mag > COUNT_WIDTH'(min_ticks);

endmodule

// ===== rtl/ooe_cordic.sv =====
// Iterative rotation unit giving cosine and sine of the heading in Q2.30.
// Depends on ooe_pkg for the arctangent table, the gain and cs_t.
module ooe_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] heading,
    output ooe_pkg::cs_t       cs
);
    import ooe_pkg::*;

    localparam logic signed [33:0] QUARTER = 34'sh0_4000_0000;
    localparam logic signed [33:0] HALF    = 34'sh0_8000_0000;

    logic signed [33:0] x_reg, y_reg, z_reg;
    logic [4:0]         i_reg;
    logic               flip_reg, busy_reg, valid_reg;
    logic signed [33:0] z0, z_fold, dx, dy, arc;
    logic               flip0;

    assign z0  = 34'(heading) <<< 16;
    assign dx  = y_reg >>> i_reg;
    assign dy  = x_reg >>> i_reg;
    assign arc = 34'(arc_angle(i_reg));

    // Headings beyond a quarter turn are folded by half a turn and negated at the end.
    always_comb
    begin
        z_fold = z0;
        flip0  = 1'b0;
        if (z0 > QUARTER)
        begin
            z_fold = z0 - HALF;
            flip0  = 1'b1;
        end
        else if (z0 < -QUARTER)
        begin
            z_fold = z0 + HALF;
            flip0  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            i_reg     <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            valid_reg <= 1'b0;
            i_reg     <= '0;
        end
        else if (busy_reg)
        begin
            i_reg <= i_reg + 5'd1;
            if (i_reg == 5'(CORDIC_STEPS - 1))
            begin
                busy_reg  <= 1'b0;
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= z_fold;
            flip_reg <= flip0;
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - arc;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + arc;
            end
        end
    end

    assign cs.valid = valid_reg;
    assign cs.cos_v = flip_reg ? -x_reg : x_reg;
    assign cs.sin_v = flip_reg ? -y_reg : y_reg;

endmodule

// ===== rtl/ooe_mul.sv =====
// Shared 64 x 64 unsigned multiplier built from one registered 32 x 32 product.
// Depends on ooe_pkg by convention only; four partial products, done pulses after the last.
module ooe_mul (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] prod,
    output logic         done
);
    logic [63:0]  a_reg, b_reg, pp_reg;
    logic [127:0] acc_reg;
    logic [2:0]   idx_reg;
    logic [1:0]   pp_sh_reg;
    logic         busy_reg, pp_vld_reg, pp_last_reg, done_reg;
    logic [31:0]  a_half, b_half;

    assign a_half = idx_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = idx_reg[0] ? b_reg[63:32] : b_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            pp_vld_reg  <= 1'b0;
            pp_last_reg <= 1'b0;
            done_reg    <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            done_reg <= pp_vld_reg && pp_last_reg;
            if (start)
            begin
                busy_reg   <= 1'b1;
                idx_reg    <= '0;
                pp_vld_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                pp_vld_reg  <= !idx_reg[2];
                pp_last_reg <= idx_reg == 3'd3;
                if (!idx_reg[2])
                begin
                    idx_reg <= idx_reg + 3'd1;
                end
                if (pp_vld_reg && pp_last_reg)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else
            begin
                pp_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else
        begin
            pp_reg    <= 64'(a_half) * 64'(b_half);
            pp_sh_reg <= {1'b0, idx_reg[1]} + {1'b0, idx_reg[0]};
            if (pp_vld_reg)
            begin
                acc_reg <= acc_reg + (128'(pp_reg) << {pp_sh_reg, 5'b0});
            end
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

// ===== rtl/ooe_div_lane.sv =====
// One output lane: restoring divider, one quotient bit a cycle, with signed saturation.
// Depends on ooe_pkg for the numerator and divisor widths.
module ooe_div_lane (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ooe_pkg::NUM_W-1:0] num,
    input  logic [ooe_pkg::DEN_W-1:0] den,
    input  logic                      neg,
    output logic                      done,
    output logic signed [31:0]        value
);
    import ooe_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg, r_reg;
    logic [32:0]      q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             ovf_reg, neg_reg, busy_reg, done_reg;
    logic [DEN_W:0]   r_sh, r_sub;
    logic             ge;
    logic [32:0]      lim, sat_v;

    assign r_sh  = {r_reg, num_reg[NUM_W-1]};
    assign r_sub = r_sh - {1'b0, den_reg};
    assign ge    = r_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            neg_reg <= neg;
            r_reg   <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            r_reg   <= ge ? r_sub[DEN_W-1:0] : r_sh[DEN_W-1:0];
            q_reg   <= {q_reg[31:0], ge};
            ovf_reg <= ovf_reg | q_reg[32];
            num_reg <= num_reg << 1;
        end
    end

    // Quotients beyond the 32-bit signed range clamp to its ends.
    assign lim   = neg_reg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    assign sat_v = (ovf_reg || q_reg > lim) ? lim : q_reg;
    assign value = neg_reg ? 32'(~sat_v + 33'd1) : sat_v[31:0];
    assign done  = done_reg;

endmodule

// ===== sim/omni_odometry_velocity_estimator_tb.sv =====
// Self-checking testbench of the omni odometry velocity estimator: directed and random
// encoder words against a built-in fixed-point kinematics predictor.
// Depends on ooe_pkg and omni_odometry_velocity_estimator from the rtl folder.
`timescale 1ns / 100ps

module omni_odometry_velocity_estimator_tb;
    import ooe_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int HOLD_CYCLES    = 4000;
    localparam int HOLD_AT_ITEM   = 400;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    item_t       item;
    logic        result_valid;
    logic        result_ready;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;

    omni_odometry_velocity_estimator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock with a 10 ns period.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Words waiting to be offered, and velocity words the predictor expects in order.
    item_t   encoder_words[$];
    result_t velocity_words[$];

    int  fail_count;
    int  words_taken;
    bit  item_fire;
    bit  calm;

    // Predictor copy of the block state and of its registers.
    logic [31:0] pred_counts[3];
    logic [31:0] pred_time;
    logic [15:0] pred_min_ticks;
    logic [15:0] pred_ticks_rev;
    logic [19:0] pred_wheel_rad;
    logic [23:0] pred_body_rad;

    // Arctangent steps of the rotation, 2^32 per turn.
    longint arc_steps[30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    function automatic logic [63:0] abs64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Signed product shifted right by k on magnitudes, clipped to the 64-bit range.
    function automatic longint scaled_product(input longint a, input longint b, input int k);
        logic [127:0] p;
        logic [63:0]  m;
        p = (128'(abs64(a)) * 128'(abs64(b))) >> k;
        m = (p > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : p[63:0];
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [31:0] clip32(input bit neg, input logic [127:0] m);
        if (neg)
        begin
            if (m > 128'h8000_0000)
                m = 128'h8000_0000;
            return 32'(-m[31:0]);
        end
        if (m > 128'h7FFF_FFFF)
            m = 128'h7FFF_FFFF;
        return m[31:0];
    endfunction

    // Rotation of the gain vector by the heading; results are cosine and sine in Q2.30.
    task automatic heading_cos_sin(input logic signed [15:0] hd, output longint c,
                                   output longint s);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = longint'(hd) * 65536;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        // Headings beyond a quarter turn are folded by half a turn and negated afterward.
        if (z > (64'sd1 <<< 30))
        begin
            z = z - (64'sd1 <<< 31);
            flip = 1'b1;
        end
        else if (z < -(64'sd1 <<< 30))
        begin
            z = z + (64'sd1 <<< 31);
            flip = 1'b1;
        end
        for (int i = 0; i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arc_steps[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arc_steps[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Works out the velocity word of one encoder word, if any wheel moved far enough.
    task automatic predict_velocity(input item_t w);
        logic [31:0]  cur[3];
        logic [31:0]  dt;
        longint       d[3];
        longint       c, s, u, p, sum, q, pq, lx, ly;
        logic [63:0]  tpr, brad, g;
        logic [127:0] den, num;
        bit           moved;
        result_t      r;
        cur[0] = w.count_a;
        cur[1] = w.count_b;
        cur[2] = w.count_c;
        moved = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = longint'(signed'(32'(cur[i] - pred_counts[i])));
            if (abs64(d[i]) > 64'(pred_min_ticks))
                moved = 1'b1;
        end
        if (!moved)
            return;
        dt = w.time_ms - pred_time;
        pred_time = w.time_ms;
        for (int i = 0; i < 3; i++)
            pred_counts[i] = cur[i];
        r = '0;
        if (dt == 0)
        begin
            r.zero_interval = 1'b1;
            velocity_words = {velocity_words, r};
            return;
        end
        // Zero divisor registers count as one.
        tpr  = (pred_ticks_rev == 0) ? 64'd1 : 64'(pred_ticks_rev);
        brad = (pred_body_rad == 0) ? 64'd1 : 64'(pred_body_rad);
        heading_cos_sin(w.heading, c, s);
        u   = d[2] - d[1];
        p   = 2 * d[0] - d[1] - d[2];
        sum = d[0] + d[1] + d[2];
        q   = scaled_product(u, 1859775393, 14);
        pq  = p * 65536;
        lx  = scaled_product(c, q, 30) - scaled_product(s, pq, 30);
        ly  = scaled_product(s, q, 30) + scaled_product(c, pq, 30);
        g   = 64'd1686629713 * 64'(pred_wheel_rad);
        den = 128'd3000 * 128'(tpr) * 128'(dt);
        num = (128'(abs64(lx)) * 128'(g)) >> 28;
        r.vel_x = clip32(lx < 0, num / den);
        num = (128'(abs64(ly)) * 128'(g)) >> 28;
        r.vel_y = clip32(ly < 0, num / den);
        num = (128'(abs64(sum)) * 128'(g * 64'd1000)) >> 12;
        num = num / (128'd3 * 128'(tpr) * 128'(dt));
        r.turn_rate = clip32(sum < 0, num / 128'(brad));
        velocity_words = {velocity_words, r};
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d (%h), actual %0d (%h)", $time, name,
                     $signed(want), want, $signed(got), got);
            fail_count++;
        end
    endtask

    // Monitor: records handshakes at the rising edge and checks each velocity word.
    always @(posedge clk)
    begin
        result_t want;
        item_fire <= item_valid && item_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MIN_TICKS: pred_min_ticks = cfg_data[15:0];
                    REG_TICKS_REV: pred_ticks_rev = cfg_data[15:0];
                    REG_WHEEL_RAD: pred_wheel_rad = cfg_data[19:0];
                    REG_BODY_RAD:  pred_body_rad  = cfg_data[23:0];
                    default: ;
                endcase
            end
            if (item_valid && item_ready)
            begin
                words_taken++;
                predict_velocity(item);
            end
            if (result_valid && result_ready)
            begin
                if (velocity_words.size() == 0)
                begin
                    $display("%0t: unexpected velocity word, expected none, actual %h",
                             $time, result);
                    fail_count++;
                end
                else
                begin
                    want = velocity_words.pop_front();
                    report_field("vel_x", want.vel_x, result.vel_x);
                    report_field("vel_y", want.vel_y, result.vel_y);
                    report_field("turn_rate", want.turn_rate, result.turn_rate);
                    report_field("zero_interval", 32'(want.zero_interval),
                                 32'(result.zero_interval));
                end
            end
        end
    end

    // Driver: offers the next pending word once the current one is taken, with random gaps unless calm.
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_fire))
        begin
            if (encoder_words.size() > 0 && (calm || $urandom_range(99) >= 9))
            begin
                item_valid <= 1'b1;
                item <= encoder_words.pop_front();
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that backs up the block.
    int  hold_left;
    bit  hold_done;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && words_taken >= HOLD_AT_ITEM)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= calm || ($urandom_range(99) >= 9);
            end
        end
    end

    // Watchdog: the run dies if nothing at all is accepted for too long.
    int quiet_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Generator state: the counts and time it last produced.
    logic [31:0] gen_counts[3];
    logic [31:0] gen_time;

    task automatic queue_word(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input logic [31:0] t,
                              input logic [15:0] h);
        item_t w;
        w.count_a = a;
        w.count_b = b;
        w.count_c = c;
        w.time_ms = t;
        w.heading = h;
        gen_counts[0] = a;
        gen_counts[1] = b;
        gen_counts[2] = c;
        gen_time = t;
        encoder_words = {encoder_words, w};
    endtask

    function automatic logic [31:0] wheel_step(input int reach);
        case (reach)
            0: return 32'($signed($urandom_range(400)) - 200);
            1: return 32'($signed($urandom_range(200000)) - 100000);
            2: return 32'($signed($urandom_range(4000000)) - 2000000);
            default: return $urandom;
        endcase
    endfunction

    // A random word: mostly plausible motion, some small jitter, some noise.
    task automatic queue_random_word();
        int          pick;
        int          reach;
        logic [31:0] t;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            queue_word($urandom, $urandom, $urandom, $urandom, 16'($urandom));
            return;
        end
        t = gen_time + $urandom_range(1, 100);
        if ($urandom_range(19) == 0)
            t = gen_time;
        else if ($urandom_range(49) == 0)
            t = $urandom;
        if (pick < 25)
        begin
            queue_word(gen_counts[0] + 32'($signed($urandom_range(6)) - 3),
                       gen_counts[1] + 32'($signed($urandom_range(6)) - 3),
                       gen_counts[2] + 32'($signed($urandom_range(6)) - 3),
                       t, 16'($urandom));
            return;
        end
        reach = $urandom_range(3);
        queue_word(gen_counts[0] + wheel_step(reach), gen_counts[1] + wheel_step(reach),
                   gen_counts[2] + wheel_step(reach), t, 16'($urandom));
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Lets every queued word through and every velocity word out, then lets the block settle.
    task automatic wait_idle();
        while (encoder_words.size() > 0 || item_valid || velocity_words.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value(input logic [31:0] lo, input logic [31:0] hi,
                                               input logic [31:0] typical);
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            default: return typical;
        endcase
    endfunction

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        fail_count   = 0;
        words_taken  = 0;
        item_fire    = 1'b0;
        calm         = 1'b0;
        hold_left    = 0;
        hold_done    = 1'b0;
        quiet_cycles = 0;
        for (int i = 0; i < 3; i++)
        begin
            pred_counts[i] = '0;
            gen_counts[i]  = '0;
        end
        pred_time      = '0;
        gen_time       = '0;
        pred_min_ticks = 16'd10;
        pred_ticks_rev = 16'd150;
        pred_wheel_rad = 20'd19000;
        pred_body_rad  = 24'd67500;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words at the reset settings: threshold edges, a zero interval,
        // headings around every quarter, count extremes and a time wrap.
        queue_word(0, 0, 0, 5, 16'sd0);
        queue_word(10, -10, 10, 6, 16'sd0);
        queue_word(11, 0, 0, 7, 16'sd0);
        queue_word(100, 0, 0, 7, 16'sd16384);
        queue_word(200, 300, -400, 20, 16'sd16384);
        queue_word(500, 100, -900, 33, -16'sd16384);
        queue_word(900, 700, 100, 40, 16'sd32767);
        queue_word(-300, 800, 600, 45, -16'sd32768);
        queue_word(0, 0, 1000, 50, 16'sd16385);
        queue_word(32'h7FFF_FFFF, 32'h8000_0000, 0, 51, 16'sd8192);
        queue_word(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 52, -16'sd16385);
        queue_word(32'h8000_1000, 32'h7FFF_0000, 1000, 32'hFFFF_FFF0, 16'sd0);
        queue_word(32'h8000_2000, 32'h7FFE_0000, 2000, 32'd5, 16'sd100);
        queue_word(32'h8000_4000, 32'h7FFD_0000, 3000, 32'h7FFF_FFFF, -16'sd100);
        wait_idle();

        // Zero divisors and a zero wheel, the lowest threshold, and an index that is ignored.
        write_reg(REG_MIN_TICKS, 32'd0);
        write_reg(REG_TICKS_REV, 32'd0);
        write_reg(REG_WHEEL_RAD, 32'd0);
        write_reg(REG_BODY_RAD, 32'd0);
        write_reg(8'd4, 32'hFFFF_FFFF);
        queue_word(1, 0, 0, 32'h8000_0000, 16'sd0);
        queue_word(5000, 9000, 1, 32'h8000_0001, 16'sd1234);
        wait_idle();
        write_reg(REG_WHEEL_RAD, 32'd1);
        write_reg(8'd255, 32'd0);
        queue_word(5001, 9000, 1, 32'h8000_0002, 16'sd0);
        queue_word(5001, 9000, 1, 32'h8000_0003, 16'sd0);
        wait_idle();

        // Highest settings: big wheel over one tick per turn saturates every lane.
        write_reg(REG_MIN_TICKS, 32'hFFFF_FFFF);
        write_reg(REG_TICKS_REV, 32'd1);
        write_reg(REG_WHEEL_RAD, 32'hFFFF_FFFF);
        write_reg(REG_BODY_RAD, 32'd1);
        queue_word(32'h7000_0000, 32'h9000_0000, 32'h4000_0000, 32'h8000_0004, 16'sd4000);
        queue_word(32'h1000_0000, 32'h1000_0000, 32'h1000_0000, 32'h8000_0005, -16'sd4000);
        queue_word(32'h1000_0000, 32'h1000_1000, 32'h1000_0000, 32'h8000_0006, 16'sd0);
        wait_idle();

        // Random phases, each behind a fresh setting; one of them runs with no stalls.
        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(REG_MIN_TICKS, pick_value(0, 65535, $urandom_range(50)));
            write_reg(REG_TICKS_REV, pick_value(1, 65535, $urandom_range(20, 2000)));
            write_reg(REG_WHEEL_RAD, pick_value(1, 1048575, $urandom_range(5000, 60000)));
            write_reg(REG_BODY_RAD, pick_value(1, 16777215, $urandom_range(30000, 300000)));
            calm = (phase == 2);
            for (int n = 0; n < 250; n++)
                queue_random_word();
            wait_idle();
        end
        calm = 1'b0;

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
